@@ hdl/fta_pkg.sv @@
package fta_pkg;

    localparam int unsigned ExpW  = 8;
    localparam int unsigned FracW = 23;
    localparam int unsigned SigW  = 24;   // significand with hidden bit
    localparam int unsigned AccW  = 26;   // two's complement sum, sign at top
    localparam int unsigned ShW   = 5;    // normalize shift amount
    localparam logic [ExpW-1:0] AlignLimit = 8'd25;

    // Stage 1 -> stage 2 payload: signed operands ready for the add
    typedef struct packed {
        logic [AccW-1:0] sig_hi;
        logic [AccW-1:0] sig_lo;
        logic [ExpW-1:0] exp;
    } fta_prep_t;

    // Leading zeros of a 24-bit magnitude; 24 when the value is zero
    function automatic logic [ShW-1:0] lead_zeros(input logic [SigW-1:0] v);
        logic [ShW-1:0] n;
        logic           found;
        n     = ShW'(SigW);
        found = 1'b0;
        for (int i = SigW - 1; i >= 0; i--) begin
            if (!found && v[i])
            begin
                n     = ShW'(SigW - 1 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

@@ hdl/fta_in_if.sv @@
interface fta_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] a_bits;
    logic [31:0] b_bits;

    modport source (output valid, output a_bits, output b_bits, input ready);
    modport sink   (input valid, input a_bits, input b_bits, output ready);
endinterface

@@ hdl/fta_out_if.sv @@
interface fta_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] sum_bits;

    modport source (output valid, output sum_bits, input ready);
    modport sink   (input valid, input sum_bits, output ready);
endinterface

@@ hdl/fta_prep.sv @@
// Operand ordering, alignment and sign conversion
module fta_prep
    import fta_pkg::*;
(
    input  logic [31:0] a_bits,
    input  logic [31:0] b_bits,
    output fta_prep_t   prep
);

    logic [31:0]     hi;
    logic [31:0]     lo;
    logic [ExpW-1:0] shamt;
    logic [SigW-1:0] sig_hi;
    logic [SigW-1:0] sig_lo;
    logic [SigW-1:0] sig_lo_al;
    logic [AccW-1:0] ext_hi;
    logic [AccW-1:0] ext_lo;

    always_comb
    begin
        // larger exponent leads; a leads on a tie
        if (a_bits[30:23] < b_bits[30:23])
        begin
            hi = b_bits;
            lo = a_bits;
        end
        else
        begin
            hi = a_bits;
            lo = b_bits;
        end
        shamt  = hi[30:23] - lo[30:23];
        sig_hi = {1'b1, hi[22:0]};
        sig_lo = {1'b1, lo[22:0]};
        if (shamt >= AlignLimit)
            sig_lo_al = '0;
        else
            sig_lo_al = sig_lo >> shamt;
        ext_hi = {2'b00, sig_hi};
        ext_lo = {2'b00, sig_lo_al};
        prep.sig_hi = hi[31] ? (~ext_hi + AccW'(1)) : ext_hi;
        prep.sig_lo = lo[31] ? (~ext_lo + AccW'(1)) : ext_lo;
        prep.exp    = hi[30:23];
    end

endmodule

@@ hdl/float32_truncating_adder.sv @@
// Truncating single-precision adder.
// Channels: operands (a_bits, b_bits) in, result (sum_bits) out, each a
// valid/ready pair; a transfer happens on a rising edge with both high.
// Every operand pair yields exactly one sum, in order.
// Throughput: one pair per cycle while result.ready is high; a pair's
// sum is valid once it has been through all four register stages (align,
// add, leading-zero count, normalize shift), each of which holds one item.
// Rounding: none, fraction is truncated. Zero, denormals, inf and NaN get
// no special treatment; the exponent wraps in 8 bits.
// Reset: rst_n (async, active low) clears all stage valid bits; the block
// comes out of reset empty and ready.
// Stall: when result.ready is low the last stage holds its sum; earlier
// stages keep filling bubbles, then operands.ready drops. Nothing is lost
// or repeated.
module float32_truncating_adder
    import fta_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    fta_in_if.sink    operands,
    fta_out_if.source result
);

    fta_prep_t prep;

    logic            v1_reg, v2_reg, v3_reg, v4_reg;
    logic            adv1, adv2, adv3, adv4;
    fta_prep_t       p1_reg;
    logic [SigW:0]   mag2_reg;
    logic            sign2_reg;
    logic [ExpW-1:0] exp2_reg;
    logic [SigW-1:0] mant3_reg;
    logic [ShW-1:0]  sh3_reg;
    logic            sign3_reg;
    logic [ExpW-1:0] exp3_reg;
    logic [31:0]     sum4_reg;

    logic [AccW-1:0] acc;
    logic [AccW-1:0] acc_abs;
    logic [ShW-1:0]  lz;
    logic [SigW-1:0] mant3_next;
    logic [ShW-1:0]  sh3_next;
    logic [ExpW-1:0] exp3_next;
    logic [SigW-1:0] shifted;

    fta_prep u_prep (
        .a_bits (operands.a_bits),
        .b_bits (operands.b_bits),
        .prep   (prep)
    );

    // stage advance: a stage loads when it is empty or moving on
    assign adv4 = !v4_reg || result.ready;
    assign adv3 = !v3_reg || adv4;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign operands.ready = adv1;
    assign result.valid    = v4_reg;
    assign result.sum_bits = sum4_reg;

    // add and take magnitude
    always_comb
    begin
        acc     = p1_reg.sig_hi + p1_reg.sig_lo;
        acc_abs = acc[AccW-1] ? (~acc + AccW'(1)) : acc;
    end

    // carry or leading-zero shift decision
    always_comb
    begin
        lz = lead_zeros(mag2_reg[SigW-1:0]);
        if (mag2_reg[SigW])
        begin
            mant3_next = mag2_reg[SigW:1];
            sh3_next   = '0;
            exp3_next  = exp2_reg + ExpW'(1);
        end
        else if (mag2_reg == '0)
        begin
            mant3_next = '0;
            sh3_next   = '0;
            exp3_next  = '0;
        end
        else if ({3'b000, lz} > exp2_reg)
        begin
            mant3_next = mag2_reg[SigW-1:0];
            sh3_next   = exp2_reg[ShW-1:0];
            exp3_next  = '0;
        end
        else
        begin
            mant3_next = mag2_reg[SigW-1:0];
            sh3_next   = lz;
            exp3_next  = exp2_reg - {3'b000, lz};
        end
    end

    assign shifted = mant3_reg << sh3_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= operands.valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (adv1 && operands.valid)
            p1_reg <= prep;
        if (adv2 && v1_reg)
        begin
            mag2_reg  <= acc_abs[SigW:0];
            sign2_reg <= acc[AccW-1];
            exp2_reg  <= p1_reg.exp;
        end
        if (adv3 && v2_reg)
        begin
            mant3_reg <= mant3_next;
            sh3_reg   <= sh3_next;
            sign3_reg <= sign2_reg;
            exp3_reg  <= exp3_next;
        end
        if (adv4 && v3_reg)
            sum4_reg <= {sign3_reg, exp3_reg, shifted[FracW-1:0]};
    end

endmodule
